// ----- rtl/tkc_pkg.sv -----
// ----------------------------------------------------------------------------
// tkc_pkg: shared types and constants of the text key cache
// Slot and key sizes, item codes, result codes and the command format that
// the front part hands to the back part.
// ----------------------------------------------------------------------------
package tkc_pkg;

  localparam int SLOTS         = 24;
  localparam int MAX_KEY_CHARS = 42;

  localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SCNT_W   = $clog2(SLOTS + 1);
  localparam int LEN_W    = $clog2(MAX_KEY_CHARS + 1);
  localparam int KI_W     = (MAX_KEY_CHARS > 1) ? $clog2(MAX_KEY_CHARS) : 1;
  localparam int KADDR_W  = $clog2(SLOTS * MAX_KEY_CHARS);
  localparam int KDEPTH   = SLOTS * MAX_KEY_CHARS;
  localparam int SLOT_ID_W = 5;
  localparam int STAMP_W  = 32;
  localparam int QDEPTH   = 2;

  localparam logic [7:0] CHAR_SPACE    = 8'd32;
  localparam logic [7:0] CHAR_LAST     = 8'd126;
  localparam logic [7:0] SCALE_NONASCII_MAX = 8'd2;

  typedef enum logic [1:0] {
    OP_CHAR    = 2'd0,
    OP_ACQUIRE = 2'd1,
    OP_FRAME   = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_HIT    = 2'd0,
    ST_MISS   = 2'd1,
    ST_REJECT = 2'd2,
    ST_NOSLOT = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_SCAN,
    B_CMP_RD,
    B_CMP_CHK,
    B_DECIDE,
    B_CP_RD,
    B_CP_WR,
    B_RESULT
  } back_state_t;

  // Command from front to back: one acquire or one begin-frame.
  typedef struct packed {
    logic             is_frame;
    logic             reject;
    logic [LEN_W-1:0] length;
    logic [7:0]       scale;
  } cmd_t;

endpackage

// ----- rtl/text_key_cache_lru_frame_pinned.sv -----
// Key character item: no result; it waits while an earlier acquire reads the key.
// Acquire item on a miss: from the queue to the result register the back part
// pops, steps through every slot, ends the scan, decides and writes the result;
// each slot of equal length is compared character by character, and the key is
// copied in; the next key waits. Begin-frame is taken when the queue has room. Reset:
// synchronous; clears slot state, stamps and counters, no clearing pass.
// ----------------------------------------------------------------------------
// text_key_cache_lru_frame_pinned: text key cache top level
// Fully associative key cache with least recently stamped replacement and
// per-frame pinning; front part and back part joined by a command queue.
// ----------------------------------------------------------------------------
module text_key_cache_lru_frame_pinned (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] op,
  input  logic [7:0] char_code,
  input  logic [7:0] scale_req,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] status,
  output logic [4:0] slot_id,
  output logic [7:0] scale_grant
);
  import tkc_pkg::*;

  logic            q_push;
  cmd_t            q_cmd;
  logic            q_full;
  logic            q_pop;
  cmd_t            q_head;
  logic            q_empty;
  logic            acq_done;
  logic [KI_W-1:0] key_rd_addr;
  logic [7:0]      key_rd_data;

  tkc_front u_front (
    .clk, .rst, .in_valid, .in_ready, .op, .char_code, .scale_req,
    .q_push, .q_cmd, .q_full, .acq_done, .key_rd_addr, .key_rd_data
  );

  tkc_fifo u_fifo (
    .clk, .rst, .push(q_push), .push_cmd(q_cmd), .full(q_full),
    .pop(q_pop), .head(q_head), .empty(q_empty)
  );

  tkc_back u_back (
    .clk, .rst, .q_head, .q_empty, .q_pop, .acq_done, .key_rd_addr, .key_rd_data,
    .out_valid, .out_ready, .status, .slot_id, .scale_grant
  );

endmodule

// ----- rtl/tkc_fifo.sv -----
// ----------------------------------------------------------------------------
// tkc_fifo: command queue
// A short queue of commands between the front part and the back part.
// ----------------------------------------------------------------------------
module tkc_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tkc_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output tkc_pkg::cmd_t head,
  output logic          empty
);
  import tkc_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  cmd_t             entries [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(QDEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Payload storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ----- rtl/tkc_front.sv -----
// ----------------------------------------------------------------------------
// tkc_front: input side of the text key cache
// Collects the pending key one character per item, checks it as it arrives
// and turns acquire and begin-frame items into queued commands.
// ----------------------------------------------------------------------------
module tkc_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              op,
  input  logic [7:0]              char_code,
  input  logic [7:0]              scale_req,
  output logic                    q_push,
  output tkc_pkg::cmd_t           q_cmd,
  input  logic                    q_full,
  input  logic                    acq_done,
  input  logic [tkc_pkg::KI_W-1:0] key_rd_addr,
  output logic [7:0]              key_rd_data
);
  import tkc_pkg::*;

  logic [7:0]       pending_key [MAX_KEY_CHARS];
  logic [LEN_W-1:0] pending_length;
  logic             pending_has_ink;
  logic             pending_nonascii;
  logic             pending_rejected;
  logic             acq_busy;
  logic             accept;
  logic             take;
  op_t              op_code;

  assign op_code = op_t'(op);

  // Characters and acquires wait while an earlier acquire still reads the key.
  always_comb begin
    case (op_code)
      OP_CHAR:    in_ready = !acq_busy;
      OP_ACQUIRE: in_ready = !acq_busy && !q_full;
      OP_FRAME:   in_ready = !q_full;
      default:    in_ready = 1'b1;
    endcase
  end

  assign accept = in_valid && in_ready;
  assign take   = accept && (op_code == OP_CHAR) && !pending_rejected &&
                  (pending_length < LEN_W'(MAX_KEY_CHARS)) && (char_code >= CHAR_SPACE);

  // Command for the back part.
  always_comb begin
    q_push         = accept && ((op_code == OP_ACQUIRE) || (op_code == OP_FRAME));
    q_cmd.is_frame = (op_code == OP_FRAME);
    q_cmd.reject   = pending_rejected || (pending_length == '0) || !pending_has_ink ||
                     (pending_nonascii && (scale_req > SCALE_NONASCII_MAX));
    q_cmd.length   = pending_length;
    q_cmd.scale    = scale_req;
  end

  // Pending key checks and acquire tracking.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_length   <= '0;
      pending_has_ink  <= 1'b0;
      pending_nonascii <= 1'b0;
      pending_rejected <= 1'b0;
      acq_busy         <= 1'b0;
    end else begin
      if (accept && (op_code == OP_ACQUIRE)) begin
        pending_length   <= '0;
        pending_has_ink  <= 1'b0;
        pending_nonascii <= 1'b0;
        pending_rejected <= 1'b0;
        acq_busy         <= 1'b1;
      end else begin
        if (acq_done) begin
          acq_busy <= 1'b0;
        end
        if (accept && (op_code == OP_CHAR) && !pending_rejected) begin
          if (take) begin
            pending_length <= pending_length + 1'b1;
            if (char_code > CHAR_LAST) begin
              pending_nonascii <= 1'b1;
            end
            if (char_code != CHAR_SPACE) begin
              pending_has_ink <= 1'b1;
            end
          end else begin
            pending_rejected <= 1'b1;
          end
        end
      end
    end
  end

  // Pending key memory: one write and one registered read port.
  always_ff @(posedge clk) begin
    if (take) begin
      pending_key[pending_length[KI_W-1:0]] <= char_code;
    end
    key_rd_data <= pending_key[key_rd_addr];
  end

endmodule

// ----- rtl/tkc_back.sv -----
// ----------------------------------------------------------------------------
// tkc_back: lookup and replacement engine of the text key cache
// Walks the slots for a hit, compares keys one character at a time, picks a
// free or least recently stamped slot, copies the key in and returns results.
// ----------------------------------------------------------------------------
module tkc_back (
  input  logic                      clk,
  input  logic                      rst,
  input  tkc_pkg::cmd_t             q_head,
  input  logic                      q_empty,
  output logic                      q_pop,
  output logic                      acq_done,
  output logic [tkc_pkg::KI_W-1:0]  key_rd_addr,
  input  logic [7:0]                key_rd_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                status,
  output logic [4:0]                slot_id,
  output logic [7:0]                scale_grant
);
  import tkc_pkg::*;

  back_state_t state;
  back_state_t state_next;

  logic [7:0]         stored_keys [KDEPTH];
  logic [LEN_W-1:0]   stored_key_lengths [SLOTS];
  logic [STAMP_W-1:0] use_stamp [SLOTS];
  logic [SLOTS-1:0]   slot_valid;
  logic [SLOTS-1:0]   used_this_frame;
  logic [STAMP_W-1:0] stamp_counter;

  cmd_t               cmd;
  logic [SCNT_W-1:0]  scan;
  logic [LEN_W-1:0]   idx;
  logic [SLOT_W-1:0]  chosen;
  logic               free_found;
  logic [SLOT_W-1:0]  free_slot;
  logic               lru_found;
  logic [SLOT_W-1:0]  lru_slot;
  logic [STAMP_W-1:0] oldest;
  status_t            res_status;
  logic [7:0]         sk_q;

  logic [SLOT_W-1:0]  scan_slot;
  logic               scan_end;
  logic               len_match;
  logic               char_eq;
  logic               last_char;
  logic               lru_take;
  logic               out_free;
  logic [SLOT_W-1:0]  addr_slot;
  logic [KADDR_W-1:0] key_addr;

  assign scan_slot = scan[SLOT_W-1:0];
  assign scan_end  = (scan == SCNT_W'(SLOTS));
  assign len_match = !scan_end && slot_valid[scan_slot] &&
                     (stored_key_lengths[scan_slot] == cmd.length);
  assign char_eq   = (sk_q == key_rd_data);
  assign last_char = (idx == cmd.length - 1'b1);
  assign out_free  = !out_valid || out_ready;
  assign lru_take  = !used_this_frame[scan_slot] &&
                     (!lru_found || (use_stamp[scan_slot] < oldest));
  assign addr_slot = (state == B_CP_WR) ? chosen : scan_slot;
  assign key_addr  = KADDR_W'(addr_slot) * KADDR_W'(MAX_KEY_CHARS) + KADDR_W'(idx);

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (!q_empty && !q_head.is_frame) begin
          state_next = q_head.reject ? B_RESULT : B_SCAN;
        end
      end
      B_SCAN: begin
        if (scan_end) begin
          state_next = B_DECIDE;
        end else if (len_match) begin
          state_next = B_CMP_RD;
        end
      end
      B_CMP_RD:  state_next = B_CMP_CHK;
      B_CMP_CHK: begin
        if (!char_eq) begin
          state_next = B_SCAN;
        end else if (last_char) begin
          state_next = B_RESULT;
        end else begin
          state_next = B_CMP_RD;
        end
      end
      B_DECIDE:  state_next = (free_found || lru_found) ? B_CP_RD : B_RESULT;
      B_CP_RD:   state_next = B_CP_WR;
      B_CP_WR:   state_next = last_char ? B_RESULT : B_CP_RD;
      B_RESULT:  state_next = out_free ? B_IDLE : B_RESULT;
      default:   state_next = B_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    q_pop       = (state == B_IDLE) && !q_empty;
    acq_done    = (state == B_RESULT) && out_free;
    key_rd_addr = idx[KI_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Working registers of the walk and the slot state.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid      <= '0;
      used_this_frame <= '0;
      stamp_counter   <= '0;
      out_valid       <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        use_stamp[i]          <= '0;
        stored_key_lengths[i] <= '0;
      end
    end else begin
      // The result register fills when the walk ends and empties on accept.
      if ((state == B_RESULT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_IDLE: begin
          if (!q_empty) begin
            cmd        <= q_head;
            scan       <= '0;
            idx        <= '0;
            free_found <= 1'b0;
            lru_found  <= 1'b0;
            res_status <= ST_REJECT;
            if (q_head.is_frame) begin
              used_this_frame <= '0;
            end
          end
        end
        B_SCAN: begin
          if (!scan_end && !len_match) begin
            if (!slot_valid[scan_slot]) begin
              if (!free_found) begin
                free_found <= 1'b1;
                free_slot  <= scan_slot;
              end
            end else if (lru_take) begin
              lru_found <= 1'b1;
              lru_slot  <= scan_slot;
              oldest    <= use_stamp[scan_slot];
            end
            scan <= scan + 1'b1;
          end
        end
        B_CMP_RD: begin
        end
        B_CMP_CHK: begin
          if (!char_eq) begin
            // Valid slot with another key: still a replacement candidate.
            if (lru_take) begin
              lru_found <= 1'b1;
              lru_slot  <= scan_slot;
              oldest    <= use_stamp[scan_slot];
            end
            scan <= scan + 1'b1;
            idx  <= '0;
          end else if (last_char) begin
            chosen     <= scan_slot;
            res_status <= ST_HIT;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        B_DECIDE: begin
          idx <= '0;
          if (free_found) begin
            chosen     <= free_slot;
            res_status <= ST_MISS;
          end else if (lru_found) begin
            chosen     <= lru_slot;
            res_status <= ST_MISS;
          end else begin
            res_status <= ST_NOSLOT;
          end
        end
        B_CP_RD: begin
        end
        B_CP_WR: begin
          idx <= idx + 1'b1;
        end
        B_RESULT: begin
          if (out_free) begin
            status <= res_status;
            if ((res_status == ST_HIT) || (res_status == ST_MISS)) begin
              slot_id                <= SLOT_ID_W'(chosen);
              scale_grant            <= cmd.scale;
              stamp_counter          <= stamp_counter + 1'b1;
              use_stamp[chosen]      <= stamp_counter + 1'b1;
              used_this_frame[chosen] <= 1'b1;
              if (res_status == ST_MISS) begin
                slot_valid[chosen]         <= 1'b1;
                stored_key_lengths[chosen] <= cmd.length;
              end
            end else begin
              slot_id     <= '0;
              scale_grant <= '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Key store: one write port for the copy, one registered read for compare.
  always_ff @(posedge clk) begin
    if (state == B_CP_WR) begin
      stored_keys[key_addr] <= key_rd_data;
    end
    sk_q <= stored_keys[key_addr];
  end

endmodule

// ----- rtl/tkc_checker.sv -----
// ----------------------------------------------------------------------------
// tkc_checker: port checks of the text key cache
// Watches the top level ports for result consistency and output handshake.
// ----------------------------------------------------------------------------
module tkc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] op,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] status,
  input logic [4:0] slot_id,
  input logic [7:0] scale_grant
);
  import tkc_pkg::*;

  // A refused or unplaceable key carries no slot and no scale.
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((status == ST_REJECT) || (status == ST_NOSLOT)) |->
      (slot_id == '0) && (scale_grant == '0))
    else $error("rejected item carries slot or scale");

  // A slot that is granted lies inside the cache.
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((status == ST_HIT) || (status == ST_MISS)) |->
      (slot_id < SLOT_ID_W'(SLOTS)))
    else $error("slot out of range");

  // A result waiting for the consumer holds its fields.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(slot_id) &&
      $stable(scale_grant))
    else $error("result changed while stalled");

  // An unused op code is always taken at once.
  a_unused_op: assert property (@(posedge clk) disable iff (rst)
    in_valid && (op == OP_NONE) |-> in_ready)
    else $error("unused op code stalled");

  // No result leaves in the cycle after reset.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result after reset");

endmodule

bind text_key_cache_lru_frame_pinned tkc_checker u_checker (
  .clk, .rst, .in_valid, .in_ready, .op, .out_valid, .out_ready,
  .status, .slot_id, .scale_grant
);
